// ===== rtl/core/swmm_pkg.sv =====
`timescale 1ns / 1ps
package swmm_pkg;

    // Window storage depth per queue
    localparam int MAX_WINDOW = 16384;
    localparam int AW         = $clog2(MAX_WINDOW);
    localparam int LEN_W      = AW + 1;
    localparam int SEQ_W      = LEN_W;
    localparam int PRICE_W    = 32;
    localparam int ENT_W      = SEQ_W + PRICE_W;
    localparam int CFG_W      = 15;
    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(16384);

    // Queue lanes
    localparam int NUM_Q = 2;
    localparam int Q_MAX = 0;
    localparam int Q_MIN = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRONT,
        ST_BACK
    } t_state;

    typedef struct packed {
        logic load;
        logic front;
        logic back;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic back_done;
    } t_sts;

    // Clamp the written length into 1 .. MAX_WINDOW
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > 32'(MAX_WINDOW)) begin
            w = 32'(MAX_WINDOW);
        end
        return LEN_W'(w);
    endfunction

    // Circular position head + off
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [AW-1:0] off);
        logic [AW:0] p;
        p = {1'b0, head} + {1'b0, off};
        if (p >= (AW+1)'(MAX_WINDOW)) begin
            p = p - (AW+1)'(MAX_WINDOW);
        end
        return p[AW-1:0];
    endfunction

endpackage

// ===== rtl/core/swmm_ram.sv =====
`timescale 1ns / 1ps
module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/core/swmm_ctrl.sv =====
`timescale 1ns / 1ps
module swmm_ctrl import swmm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_bar_valid,
    output logic o_bar_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_bar_valid) begin
                    n_state = ST_FRONT;
                end
            end
            ST_FRONT: begin
                if (i_sts.out_free) begin
                    n_state = ST_BACK;
                end
            end
            ST_BACK: begin
                if (i_sts.back_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_bar_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_bar_ready = 1'b1;
                o_cmd.load  = i_bar_valid;
            end
            ST_FRONT: begin
                o_cmd.front = i_sts.out_free;
            end
            ST_BACK: begin
                o_cmd.back = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/swmm_datapath.sv =====
`timescale 1ns / 1ps
module swmm_datapath import swmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [PRICE_W-1:0] i_bar_high,
    input  logic [PRICE_W-1:0] i_bar_low,
    input  logic               i_cfg_wr,
    input  logic [CFG_W-1:0]   i_window_length,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [PRICE_W-1:0] o_window_high,
    output logic [PRICE_W-1:0] o_window_low,
    output logic               o_window_valid
);

    logic [PRICE_W-1:0] r_val  [NUM_Q];
    logic [AW-1:0]      r_head [NUM_Q];
    logic [AW-1:0]      n_head [NUM_Q];
    logic [LEN_W-1:0]   r_qlen [NUM_Q];
    logic [LEN_W-1:0]   n_qlen [NUM_Q];
    logic               r_done [NUM_Q];
    logic               n_done [NUM_Q];
    logic [SEQ_W-1:0]   r_cnt;
    logic [SEQ_W-1:0]   n_cnt;
    logic               r_full;
    logic               n_full;
    logic [LEN_W-1:0]   r_len;
    logic               r_res_valid;

    logic               wr_en   [NUM_Q];
    logic [AW-1:0]      wr_addr [NUM_Q];
    logic [ENT_W-1:0]   wr_data [NUM_Q];
    logic               rd_en   [NUM_Q];
    logic [AW-1:0]      rd_addr [NUM_Q];
    logic [ENT_W-1:0]   rd_data [NUM_Q];
    logic [PRICE_W-1:0] rd_price [NUM_Q];
    logic [SEQ_W-1:0]   rd_age  [NUM_Q];
    logic               pop     [NUM_Q];
    logic               all_done;
    logic [LEN_W:0]     cnt_inc;

    for (genvar g = 0; g < NUM_Q; g++) begin : g_queue
        swmm_ram #(
            .WIDTH (ENT_W),
            .DEPTH (MAX_WINDOW)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_addr[g]),
            .i_wr_data (wr_data[g]),
            .i_rd_en   (rd_en[g]),
            .i_rd_addr (rd_addr[g]),
            .o_rd_data (rd_data[g])
        );
    end

    always_comb begin
        for (int q = 0; q < NUM_Q; q++) begin
            rd_price[q] = rd_data[q][PRICE_W-1:0];
            rd_age[q]   = r_cnt - rd_data[q][ENT_W-1:PRICE_W];
            // Ties evict the older entry
            pop[q]      = (q == Q_MAX) ? (r_val[q] >= rd_price[q])
                                       : (r_val[q] <= rd_price[q]);
            n_head[q]   = r_head[q];
            n_qlen[q]   = r_qlen[q];
            n_done[q]   = r_done[q];
            rd_en[q]    = 1'b0;
            rd_addr[q]  = r_head[q];
            wr_en[q]    = 1'b0;
            wr_addr[q]  = slot(r_head[q], AW'(r_qlen[q]));
            wr_data[q]  = {r_cnt, r_val[q]};

            if (i_cmd.load) begin
                rd_en[q] = 1'b1;
            end

            if (i_cmd.front) begin
                n_done[q] = 1'b0;
                // At most one front entry ages out per bar
                if (r_qlen[q] != '0 && rd_age[q] >= r_len) begin
                    n_head[q] = slot(r_head[q], AW'(1));
                    n_qlen[q] = r_qlen[q] - LEN_W'(1);
                end
                rd_en[q]   = 1'b1;
                rd_addr[q] = slot(n_head[q], AW'(n_qlen[q] - LEN_W'(1)));
            end

            if (i_cmd.back && !r_done[q]) begin
                if (r_qlen[q] != '0 && pop[q]) begin
                    n_qlen[q]  = r_qlen[q] - LEN_W'(1);
                    rd_en[q]   = 1'b1;
                    rd_addr[q] = slot(r_head[q], AW'(r_qlen[q] - LEN_W'(2)));
                end else begin
                    wr_en[q]  = 1'b1;
                    n_qlen[q] = r_qlen[q] + LEN_W'(1);
                    n_done[q] = 1'b1;
                end
            end
        end

        all_done = n_done[Q_MAX] & n_done[Q_MIN];
        cnt_inc  = (LEN_W+1)'(r_cnt) + (LEN_W+1)'(1);
        n_cnt    = r_cnt;
        n_full   = r_full;
        if (i_cmd.back && all_done) begin
            n_cnt = r_cnt + SEQ_W'(1);
            if (cnt_inc >= (LEN_W+1)'(r_len)) begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q] <= '0;
                r_qlen[q] <= '0;
                r_done[q] <= 1'b1;
            end
            r_cnt  <= '0;
            r_full <= 1'b0;
            r_len  <= eff_len(LEN_RESET);
        end else if (i_cfg_wr) begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q] <= '0;
                r_qlen[q] <= '0;
                r_done[q] <= 1'b1;
            end
            r_cnt  <= '0;
            r_full <= 1'b0;
            r_len  <= eff_len(i_window_length);
        end else begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q] <= n_head[q];
                r_qlen[q] <= n_qlen[q];
                r_done[q] <= n_done[q];
            end
            r_cnt  <= n_cnt;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.front) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val[Q_MAX] <= i_bar_high;
            r_val[Q_MIN] <= i_bar_low;
        end
        if (i_cmd.front) begin
            o_window_high  <= (r_qlen[Q_MAX] != '0) ? rd_price[Q_MAX] : '0;
            o_window_low   <= (r_qlen[Q_MIN] != '0) ? rd_price[Q_MIN] : '1;
            o_window_valid <= r_full;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_sts.out_free  = !r_res_valid || i_res_ready;
    assign o_sts.back_done = all_done;

endmodule

// ===== rtl/core/sliding_window_max_min.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------
// bar in   | i_bar_valid / o_bar_ready  | i_bar_high[31:0], i_bar_low[31:0]
// result   | o_res_valid / i_res_ready  | o_window_high, o_window_low, o_window_valid
// config   | i_cfg_valid / o_cfg_ready  | i_window_length[14:0]
//
// One bar passes from its transfer through one front step and P + 1 back steps
// before the next transfer, where P is the larger number of back pops of the
// two queues; each pop costs one registered read of the queue RAM.
// Pops amortize to at most one per bar.
// Reset is synchronous; queue RAMs need no clearing, empty queues are tracked
// by length. A result waiting in the output register stalls the front step
// only when a new result is due and the old one has not been taken.
module sliding_window_max_min import swmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // bar input
    input  logic               i_bar_valid,
    output logic               o_bar_ready,
    input  logic [PRICE_W-1:0] i_bar_high,
    input  logic [PRICE_W-1:0] i_bar_low,
    // result output
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [PRICE_W-1:0] o_window_high,
    output logic [PRICE_W-1:0] o_window_low,
    output logic               o_window_valid,
    // window length write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_window_length
);

    t_cmd cmd;
    t_sts sts;

    // The user must write only while idle; the block itself does not enforce it.
    // Take each transfer at once and restart the window.
    assign o_cfg_ready = 1'b1;

    swmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bar_valid (i_bar_valid),
        .o_bar_ready (o_bar_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Two monotonic queues: falling highs and rising lows, each in its own RAM.
    swmm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_bar_high      (i_bar_high),
        .i_bar_low       (i_bar_low),
        .i_cfg_wr        (i_cfg_valid),
        .i_window_length (i_window_length),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_window_high   (o_window_high),
        .o_window_low    (o_window_low),
        .o_window_valid  (o_window_valid)
    );

endmodule
